// ===== rtl/fifo_dma_lock_arbiter_macros.svh =====
// ----------------------------------------------------------------------------
// fifo_dma_lock_arbiter_macros.svh
// assertion helpers for the dma lock arbiter
// ----------------------------------------------------------------------------
`ifndef FIFO_DMA_LOCK_ARBITER_MACROS_SVH
`define FIFO_DMA_LOCK_ARBITER_MACROS_SVH

// same-cycle implication, checked out of reset
`define FDLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FDLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fdla_pkg.sv =====
// ----------------------------------------------------------------------------
// fdla_pkg
// shared types, codes and a ring helper for the dma lock arbiter
// ----------------------------------------------------------------------------
`default_nettype none

package fdla_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 4;
  localparam int ENTRY_W     = ID_W + 1;

  typedef logic [PTR_W-1:0]   ptr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ID_W-1:0]    id_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // action codes
  typedef enum logic [1:0] {
    ACT_GRAB = 2'd0,
    ACT_FREE = 2'd1,
    ACT_IRQ  = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTOWNER = 2'd3
  } status_t;

  // notify codes for a new owner
  localparam logic [1:0] NOTE_DIRECT   = 2'd0;
  localparam logic [1:0] NOTE_WAKE     = 2'd1;
  localparam logic [1:0] NOTE_CALLBACK = 2'd2;

  // control states
  typedef enum logic {
    ARB_IDLE = 1'b0,
    ARB_EXEC = 1'b1
  } arb_state_t;

  // ring position ptr + off, off below the depth
  function automatic ptr_t ring_add(input ptr_t ptr, input cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fifo_dma_lock_arbiter.sv =====
// ----------------------------------------------------------------------------
// fifo_dma_lock_arbiter
// first-come lock queue for a shared dma engine, kept in a ring ram
// ----------------------------------------------------------------------------
// a result is registered from the latched request in the exec state, which waits
//   while the last result is unaccepted; no new request is taken before its commit,
//   and the registered ram read of the head and next queue entries precedes each update
// reset: synchronous active low, clears head, count, state and output valid;
//   the queue ram is not cleared, only live entries are ever read
`default_nettype none

`include "fifo_dma_lock_arbiter_macros.svh"

module fifo_dma_lock_arbiter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_action,
  input  wire logic [3:0]          in_requester_id,
  input  wire logic                in_has_callback,
  input  wire logic                in_return_direct,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic                     out_grant_valid,
  output logic [3:0]               out_grant_id,
  output logic [1:0]               out_grant_notify,
  output logic                     out_irq_valid,
  output logic [3:0]               out_irq_owner,
  output logic                     out_others_waiting,
  output logic [4:0]               out_queue_count
);
  import fdla_pkg::*;

  // control state
  arb_state_t state_r, state_nxt;
  ptr_t       head_r, head_nxt;
  cnt_t       cnt_r, cnt_nxt;
  logic       out_valid_r;

  // latched request
  action_t    act_r;
  id_t        id_r;
  logic       cb_r;
  logic       rdir_r;

  // queue ram and its registered read ports
  entry_t     mem [QUEUE_DEPTH];
  entry_t     rd_head_r;
  entry_t     rd_next_r;
  logic       wr_en;
  ptr_t       wr_addr;
  entry_t     wr_data;

  // fsm outputs
  logic       accept;
  logic       commit;

  // result being formed
  status_t    res_status;
  logic       res_gvalid;
  id_t        res_gid;
  logic [1:0] res_gnote;
  logic       res_ivalid;
  id_t        res_iowner;

  // output registers
  logic [1:0] status_r;
  logic       gvalid_r;
  id_t        gid_r;
  logic [1:0] gnote_r;
  logic       ivalid_r;
  id_t        iowner_r;
  logic       others_r;
  logic [4:0] qcount_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ARB_IDLE: begin
        if (in_valid) state_nxt = ARB_EXEC;
      end
      ARB_EXEC: begin
        if (!out_valid_r || out_ready) state_nxt = ARB_IDLE;
      end
      default: state_nxt = ARB_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready = 1'b0;
    commit   = 1'b0;
    case (state_r)
      ARB_IDLE: in_ready = 1'b1;
      ARB_EXEC: commit   = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
        commit   = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ARB_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // capture the request on an input transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= action_t'(in_action);
      id_r   <= in_requester_id;
      cb_r   <= in_has_callback;
      rdir_r <= in_return_direct;
    end
  end

  // queue ram: one write port, head and next read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_head_r <= mem[head_r];
    rd_next_r <= mem[ring_add(head_r, CNT_W'(1))];
  end

  // update of the queue and the result
  always_comb begin
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    wr_en      = 1'b0;
    wr_addr    = ring_add(head_r, cnt_r);
    wr_data    = {cb_r, id_r};
    res_status = ST_OK;
    res_gvalid = 1'b0;
    res_gid    = '0;
    res_gnote  = NOTE_DIRECT;
    res_ivalid = 1'b0;
    res_iowner = '0;
    case (act_r)
      ACT_GRAB: begin
        if (cnt_r == CNT_W'(QUEUE_DEPTH)) begin
          res_status = ST_FULL;
        end else begin
          wr_en   = commit;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == '0) begin
            res_gvalid = 1'b1;
            res_gid    = id_r;
            res_gnote  = (rdir_r || !cb_r) ? NOTE_DIRECT : NOTE_CALLBACK;
          end
        end
      end
      ACT_FREE: begin
        if (cnt_r == '0) begin
          res_status = ST_EMPTY;
        end else begin
          if (rd_head_r[ID_W-1:0] != id_r) res_status = ST_NOTOWNER;
          head_nxt = ring_add(head_r, CNT_W'(1));
          cnt_nxt  = cnt_r - CNT_W'(1);
          if (cnt_r != CNT_W'(1)) begin
            res_gvalid = 1'b1;
            res_gid    = rd_next_r[ID_W-1:0];
            res_gnote  = rd_next_r[ID_W] ? NOTE_CALLBACK : NOTE_WAKE;
          end
        end
      end
      ACT_IRQ: begin
        if (cnt_r != '0) begin
          res_ivalid = 1'b1;
          res_iowner = rd_head_r[ID_W-1:0];
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // head and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (commit) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status_r <= res_status;
      gvalid_r <= res_gvalid;
      gid_r    <= res_gid;
      gnote_r  <= res_gnote;
      ivalid_r <= res_ivalid;
      iowner_r <= res_iowner;
      others_r <= cnt_nxt > CNT_W'(1);
      qcount_r <= 5'((CNT_W+5)'(cnt_nxt));
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_grant_valid    = gvalid_r;
  assign out_grant_id       = gid_r;
  assign out_grant_notify   = gnote_r;
  assign out_irq_valid      = ivalid_r;
  assign out_irq_owner      = iowner_r;
  assign out_others_waiting = others_r;
  assign out_queue_count    = qcount_r;

  // checks
  `FDLA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(QUEUE_DEPTH), "queue count above depth")
  `FDLA_ASSERT_NOW(a_grant_irq_excl, out_valid && out_grant_valid, !out_irq_valid,
    "grant and interrupt in one result")
  `FDLA_ASSERT_NEXT(a_accept_exec, accept, state_r == ARB_EXEC, "transfer not followed by exec")
  `FDLA_ASSERT_NOW(a_head_moves_on_free, !$stable(head_r),
    $past(commit) && $past(act_r) == ACT_FREE, "head moved without a free")

endmodule

`default_nettype wire

// ===== dv/fifo_dma_lock_arbiter_checker.sv =====
// ----------------------------------------------------------------------------
// fifo_dma_lock_arbiter_checker
// watches both channels of the dma lock arbiter, keeps its own copy of the
// lock queue, predicts each result and compares it field by field
// ----------------------------------------------------------------------------

module fifo_dma_lock_arbiter_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [3:0] in_requester_id,
  input  logic       in_has_callback,
  input  logic       in_return_direct,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] out_status,
  input  logic       out_grant_valid,
  input  logic [3:0] out_grant_id,
  input  logic [1:0] out_grant_notify,
  input  logic       out_irq_valid,
  input  logic [3:0] out_irq_owner,
  input  logic       out_others_waiting,
  input  logic [4:0] out_queue_count,
  output int         mismatch_count,
  output int         pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import fdla_pkg::*;

  typedef struct packed {
    status_t    status;
    logic       grant_valid;
    id_t        grant_id;
    logic [1:0] grant_notify;
    logic       irq_valid;
    id_t        irq_owner;
    logic       others_waiting;
    logic [4:0] queue_count;
  } lock_result_t;

  // shadow lock queue: entry is {has_callback, requester_id}
  entry_t       lock_ring [QUEUE_DEPTH];
  int unsigned  lock_head  = 0;
  int unsigned  lock_depth = 0;
  lock_result_t expected_results [$];
  int           fault_tally  = 0;
  int           result_index = 0;

  function automatic int unsigned ring_slot(int unsigned off);
    return (lock_head + off) % QUEUE_DEPTH;
  endfunction

  // apply one accepted transfer to the shadow queue and build its result
  function automatic lock_result_t advance_lock(action_t act, id_t id, logic cb, logic rdir);
    lock_result_t res;
    entry_t       next;
    res = '0;
    res.status = ST_OK;
    case (act)
      ACT_GRAB: begin
        if (lock_depth >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          lock_ring[ring_slot(lock_depth)] = {cb, id};
          lock_depth++;
          // first in line gets the lock right away
          if (lock_depth == 1) begin
            res.grant_valid  = 1'b1;
            res.grant_id     = id;
            res.grant_notify = (rdir || !cb) ? NOTE_DIRECT : NOTE_CALLBACK;
          end
        end
      end
      ACT_FREE: begin
        if (lock_depth == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // a release by someone else still drops the head
          if (lock_ring[ring_slot(0)][ID_W-1:0] != id) begin
            res.status = ST_NOTOWNER;
          end
          lock_head = ring_slot(1);
          lock_depth--;
          if (lock_depth > 0) begin
            next             = lock_ring[ring_slot(0)];
            res.grant_valid  = 1'b1;
            res.grant_id     = next[ID_W-1:0];
            res.grant_notify = next[ID_W] ? NOTE_CALLBACK : NOTE_WAKE;
          end
        end
      end
      ACT_IRQ: begin
        if (lock_depth > 0) begin
          res.irq_valid = 1'b1;
          res.irq_owner = lock_ring[ring_slot(0)][ID_W-1:0];
        end
      end
      default: begin
      end
    endcase
    res.others_waiting = (lock_depth > 1);
    res.queue_count    = 5'(lock_depth);
    return res;
  endfunction

  task automatic log_mismatch(string msg);
    $display("%0t ns: result %0d: %s", $time, result_index, msg);
    fault_tally++;
  endtask

  task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("%s got 0x%0h, predicted 0x%0h", name, got, want));
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin : sample
    lock_result_t want;
    if (!rst_n) begin
      lock_head  = 0;
      lock_depth = 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(advance_lock(action_t'(in_action), in_requester_id,
                                                in_has_callback, in_return_direct));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          log_mismatch("result transfer with nothing predicted");
        end else begin
          want = expected_results.pop_front();
          compare_field("status", out_status, want.status);
          compare_field("grant_valid", out_grant_valid, want.grant_valid);
          compare_field("grant_id", out_grant_id, want.grant_id);
          compare_field("grant_notify", out_grant_notify, want.grant_notify);
          compare_field("irq_valid", out_irq_valid, want.irq_valid);
          compare_field("irq_owner", out_irq_owner, want.irq_owner);
          compare_field("others_waiting", out_others_waiting, want.others_waiting);
          compare_field("queue_count", out_queue_count, want.queue_count);
        end
        result_index++;
      end
    end
    mismatch_count <= fault_tally;
    pending_count  <= expected_results.size();
  end

endmodule

// ===== dv/fifo_dma_lock_arbiter_tb.sv =====
// ----------------------------------------------------------------------------
// fifo_dma_lock_arbiter_tb
// drives grab, free, interrupt and unused requests into the dma lock arbiter:
// a short directed run over empty, full and wrong-owner cases, then random
// fill and drain bursts under several sender and receiver idling patterns;
// the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------

module fifo_dma_lock_arbiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdla_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_action;
  logic [3:0] in_requester_id;
  logic       in_has_callback;
  logic       in_return_direct;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_status;
  logic       out_grant_valid;
  logic [3:0] out_grant_id;
  logic [1:0] out_grant_notify;
  logic       out_irq_valid;
  logic [3:0] out_irq_owner;
  logic       out_others_waiting;
  logic [4:0] out_queue_count;
  int         mismatches;
  int         pending;

  idle_mode_t idle_mode = IDLE_NONE;
  bit         fill_bias;
  // requester ids in lock order, only used to aim frees at the owner
  id_t        lock_line [$];

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fifo_dma_lock_arbiter u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_requester_id    (in_requester_id),
    .in_has_callback    (in_has_callback),
    .in_return_direct   (in_return_direct),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_grant_valid    (out_grant_valid),
    .out_grant_id       (out_grant_id),
    .out_grant_notify   (out_grant_notify),
    .out_irq_valid      (out_irq_valid),
    .out_irq_owner      (out_irq_owner),
    .out_others_waiting (out_others_waiting),
    .out_queue_count    (out_queue_count)
  );

  fifo_dma_lock_arbiter_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_requester_id    (in_requester_id),
    .in_has_callback    (in_has_callback),
    .in_return_direct   (in_return_direct),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_grant_valid    (out_grant_valid),
    .out_grant_id       (out_grant_id),
    .out_grant_notify   (out_grant_notify),
    .out_irq_valid      (out_irq_valid),
    .out_irq_owner      (out_irq_owner),
    .out_others_waiting (out_others_waiting),
    .out_queue_count    (out_queue_count),
    .mismatch_count     (mismatches),
    .pending_count      (pending)
  );

  // decide whether one side sits out this cycle
  function automatic bit roll_idle(bit sender_side);
    case (idle_mode)
      IDLE_SENDER:   return sender_side && ($urandom_range(99) < 75);
      IDLE_RECEIVER: return !sender_side && ($urandom_range(99) < 75);
      IDLE_BOTH:     return $urandom_range(99) < 8;
      default:       return 1'b0;
    endcase
  endfunction

  // result side back-pressure, changed at the falling edge
  always @(negedge clk) begin
    out_ready <= !roll_idle(1'b0);
  end

  // one request transfer; entered and left at a falling edge
  task automatic send_transfer(action_t act, id_t id, logic cb, logic rdir);
    while (roll_idle(1'b1)) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_action        = act;
    in_requester_id  = id;
    in_has_callback  = cb;
    in_return_direct = rdir;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (act == ACT_GRAB && lock_line.size() < QUEUE_DEPTH) begin
      lock_line.push_back(id);
    end else if (act == ACT_FREE && lock_line.size() > 0) begin
      void'(lock_line.pop_front());
    end
  endtask

  // random request, biased toward filling or draining the queue
  task automatic send_random();
    int      roll;
    id_t     id;
    action_t act;
    roll = $urandom_range(99);
    if (fill_bias) begin
      act = (roll < 70) ? ACT_GRAB : (roll < 88) ? ACT_FREE : (roll < 96) ? ACT_IRQ : ACT_NOP;
    end else begin
      act = (roll < 20) ? ACT_GRAB : (roll < 80) ? ACT_FREE : (roll < 94) ? ACT_IRQ : ACT_NOP;
    end
    id = 4'($urandom_range(15));
    // mostly release by the real owner, sometimes by a stranger
    if (act == ACT_FREE && lock_line.size() > 0 && $urandom_range(99) < 85) begin
      id = lock_line[0];
    end
    send_transfer(act, id, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // stimulus and verdict
  initial begin
    idle_mode_t phase_modes [4];
    phase_modes      = '{IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_action        = ACT_GRAB;
    in_requester_id  = '0;
    in_has_callback  = 1'b0;
    in_return_direct = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty queue corners and the unused action
    send_transfer(ACT_FREE, 4'd0, 1'b0, 1'b0);
    send_transfer(ACT_IRQ, 4'd0, 1'b0, 1'b0);
    send_transfer(ACT_NOP, 4'd15, 1'b1, 1'b1);
    // immediate grant with callback, then interrupt to the owner
    send_transfer(ACT_GRAB, 4'd0, 1'b1, 1'b0);
    send_transfer(ACT_IRQ, 4'd9, 1'b0, 1'b0);
    // fill up behind the owner
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      send_transfer(ACT_GRAB, id_t'(i), i[0], i[1]);
    end
    // grab on a full queue
    send_transfer(ACT_GRAB, 4'd15, 1'b1, 1'b1);
    // release by a stranger, then by the owner
    send_transfer(ACT_FREE, 4'd7, 1'b0, 1'b0);
    send_transfer(ACT_FREE, 4'd1, 1'b0, 1'b0);

    // random: fill and drain bursts under each idling pattern
    foreach (phase_modes[p]) begin
      idle_mode = phase_modes[p];
      for (int i = 0; i < 125; i++) begin
        if (i % 40 == 0) begin
          fill_bias = 1'($urandom_range(1));
        end
        send_random();
      end
    end
    in_valid = 1'b0;

    // drain and settle
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run time guard
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
